/* hdl/htbd_pkg.sv */
// ----------------------------------------------------------------------------
// htbd_pkg: shared types and constants of the Huffman tree build decoder
// Command format between the front queue and the decode engine, sizes of the
// alphabet list and of the node store.
// ----------------------------------------------------------------------------
package htbd_pkg;

   localparam int MAX_SYMBOLS = 256;
   localparam int WEIGHT_BITS = 32;
   localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
   localparam int LIST_AW     = $clog2(MAX_SYMBOLS);
   localparam int LEN_W       = LIST_AW + 1;
   localparam int NODE_AW     = 9;
   localparam int NODE_W      = 27;
   localparam int LEAF_BIT    = 26;
   localparam int SYM_LSB     = 18;
   localparam int NBITS_W     = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      OP_ENTRY = 1'b0,
      OP_DATA  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [7:0]             symbol;
      logic [WEIGHT_BITS-1:0] frequency;
      logic [7:0]             data_byte;
      logic                   last;
      logic [NBITS_W-1:0]     nbits;
   } cmd_type;

endpackage

/* hdl/htbd_front.sv */
// ----------------------------------------------------------------------------
// htbd_front: input queue of the Huffman tree build decoder
// Accepts request transactions, classifies them into entry or payload commands
// with the count of bits to decode, and queues them for the engine.
// ----------------------------------------------------------------------------
module htbd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [7:0]                    req_entry_symbol,
   input  logic [31:0]                   req_entry_frequency,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   input  logic [2:0]                    req_pad_bits,
   output logic                          cmd_vld,
   output htbd_pkg::cmd_type             cmd,
   input  logic                          cmd_pop
);
   import htbd_pkg::*;

   cmd_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      cnt_ff, cnt_in;
   cmd_type                new_cmd;
   logic                   push;
   logic                   pop;

   always_comb begin
      new_cmd.op        = req_kind ? OP_DATA : OP_ENTRY;
      new_cmd.symbol    = req_entry_symbol;
      new_cmd.frequency = WEIGHT_BITS'(req_entry_frequency);
      new_cmd.data_byte = req_data_byte;
      new_cmd.last      = req_last_byte;
      // only the final byte carries padding
      new_cmd.nbits     = req_last_byte ? NBITS_W'(4'd8 - {1'b0, req_pad_bits})
                                        : NBITS_W'(4'd8);
   end

   assign req_stall = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_vld   = (cnt_ff != '0);
   assign pop       = cmd_pop && cmd_vld;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* hdl/htbd_back.sv */
// ----------------------------------------------------------------------------
// htbd_back: tree build and decode engine
// Loads alphabet entries, builds the code tree by repeated two-minimum merges
// over the working list, then walks the tree one payload bit per cycle while no
// decoded symbol waits on a stalled output register, which delivers the symbols.
// ----------------------------------------------------------------------------
module htbd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_vld,
   input  htbd_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_symbol,
   output logic                          rsp_last_of_run
);
   import htbd_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_SCAN    = 9'b000000010,
      S_MERGE   = 9'b000000100,
      S_SH_RD   = 9'b000001000,
      S_SH_WR   = 9'b000010000,
      S_ROOT_RD = 9'b000100000,
      S_ROOT_WR = 9'b001000000,
      S_WALK    = 9'b010000000,
      S_FLUSH   = 9'b100000000
   } state_type;

   // memories
   logic [NODE_W-1:0]      tree_mem [NODE_DEPTH];
   logic [NODE_AW-1:0]     lref_mem [MAX_SYMBOLS];
   logic [WEIGHT_BITS-1:0] lw_mem   [MAX_SYMBOLS];

   logic                   tree_we, tree_re;
   logic [NODE_AW-1:0]     tree_wa, tree_ra;
   logic [NODE_W-1:0]      tree_wd, tree_rd_ff;
   logic                   list_we, list_re;
   logic [LIST_AW-1:0]     list_wa, list_ra;
   logic [NODE_AW-1:0]     list_wref, lref_rd_ff;
   logic [WEIGHT_BITS-1:0] list_ww, lw_rd_ff;

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [NODE_AW-1:0]     ncnt_ff, ncnt_in;
   logic                   ready_ff, ready_in;
   logic [LEN_W-1:0]       scan_ff, scan_in;
   logic                   rdv_ff, rdv_in;
   logic [LIST_AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [LIST_AW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic                   hi_vld_ff, hi_vld_in;
   logic [WEIGHT_BITS-1:0] wlo_ff, wlo_in, whi_ff, whi_in;
   logic [NODE_AW-1:0]     rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic [LIST_AW-1:0]     sh_ff, sh_in;
   logic [NODE_W-1:0]      root_ff, root_in, cur_ff, cur_in;
   logic [NBITS_W-1:0]     bit_ff, bit_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [7:0]             pend_sym_ff, pend_sym_in;
   logic                   rsp_vld_ff;
   logic [7:0]             rsp_sym_ff;
   logic                   rsp_last_ff;

   logic                   out_take, out_push, out_last;
   logic [7:0]             out_sym;
   logic [WEIGHT_BITS:0]   sum_w;
   logic [WEIGHT_BITS-1:0] sat_w;
   logic [LIST_AW-1:0]     new_k;
   logic                   leaf_hit, walk_hold, code_bit;
   logic [NODE_W-1:0]      cur_eff;

   assign out_take = !rsp_vld_ff || !rsp_stall;
   assign sum_w    = {1'b0, wlo_ff} + {1'b0, whi_ff};
   assign sat_w    = sum_w[WEIGHT_BITS] ? '1 : sum_w[WEIGHT_BITS-1:0];
   assign new_k    = ready_ff ? '0 : len_ff[LIST_AW-1:0];
   assign leaf_hit = (bit_ff != '0) && tree_rd_ff[LEAF_BIT];
   assign cur_eff  = (bit_ff == '0) ? cur_ff : (leaf_hit ? root_ff : tree_rd_ff);
   assign walk_hold = leaf_hit && pend_vld_ff && !out_take;
   assign code_bit = cmd.data_byte[~bit_ff[2:0]];

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      ncnt_in     = ncnt_ff;
      ready_in    = ready_ff;
      scan_in     = scan_ff;
      rdv_in      = rdv_ff;
      rd_idx_in   = rd_idx_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      hi_vld_in   = hi_vld_ff;
      wlo_in      = wlo_ff;
      whi_in      = whi_ff;
      rlo_in      = rlo_ff;
      rhi_in      = rhi_ff;
      sh_in       = sh_ff;
      root_in     = root_ff;
      cur_in      = cur_ff;
      bit_in      = bit_ff;
      pend_vld_in = pend_vld_ff;
      pend_sym_in = pend_sym_ff;
      cmd_pop     = 1'b0;
      out_push    = 1'b0;
      out_sym     = pend_sym_ff;
      out_last    = 1'b0;
      tree_we     = 1'b0;
      tree_wa     = ncnt_ff;
      tree_wd     = {1'b0, 8'd0, rlo_ff, rhi_ff};
      tree_re     = 1'b0;
      tree_ra     = rlo_ff;
      list_we     = 1'b0;
      list_wa     = lo_ff;
      list_wref   = ncnt_ff;
      list_ww     = sat_w;
      list_re     = 1'b0;
      list_ra     = scan_ff[LIST_AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_vld) begin
               if (cmd.op == OP_ENTRY) begin
                  cmd_pop = 1'b1;
                  // a loaded tree is dropped, the entry opens a new alphabet
                  if (ready_ff || (len_ff < LEN_W'(MAX_SYMBOLS))) begin
                     tree_we   = 1'b1;
                     tree_wa   = NODE_AW'(new_k);
                     tree_wd   = {1'b1, cmd.symbol, 18'd0};
                     list_we   = 1'b1;
                     list_wa   = new_k;
                     list_wref = NODE_AW'(new_k);
                     list_ww   = cmd.frequency;
                     len_in    = LEN_W'(new_k) + 1'b1;
                     ncnt_in   = NODE_AW'(new_k) + 1'b1;
                     ready_in  = 1'b0;
                  end
               end else if (ready_ff) begin
                  bit_in      = '0;
                  pend_vld_in = 1'b0;
                  state_in    = root_ff[LEAF_BIT] ? S_FLUSH : S_WALK;
               end else if (len_ff == '0) begin
                  cmd_pop = 1'b1;
               end else begin
                  scan_in  = '0;
                  rdv_in   = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_ff < len_ff) begin
               list_re   = 1'b1;
               list_ra   = scan_ff[LIST_AW-1:0];
               scan_in   = scan_ff + 1'b1;
               rdv_in    = 1'b1;
               rd_idx_in = scan_ff[LIST_AW-1:0];
            end else begin
               rdv_in = 1'b0;
            end
            if (rdv_ff) begin
               if (rd_idx_ff == '0) begin
                  lo_in     = '0;
                  wlo_in    = lw_rd_ff;
                  rlo_in    = lref_rd_ff;
                  hi_vld_in = 1'b0;
               end else if (lw_rd_ff < wlo_ff) begin
                  hi_in     = lo_ff;
                  whi_in    = wlo_ff;
                  rhi_in    = rlo_ff;
                  hi_vld_in = 1'b1;
                  lo_in     = rd_idx_ff;
                  wlo_in    = lw_rd_ff;
                  rlo_in    = lref_rd_ff;
               end else if (!hi_vld_ff || (lw_rd_ff < whi_ff)) begin
                  hi_in     = rd_idx_ff;
                  whi_in    = lw_rd_ff;
                  rhi_in    = lref_rd_ff;
                  hi_vld_in = 1'b1;
               end
            end else if (scan_ff == len_ff) begin
               state_in = (len_ff == LEN_W'(1)) ? S_ROOT_RD : S_MERGE;
            end
         end
         S_MERGE: begin
            tree_we = 1'b1;
            list_we = 1'b1;
            ncnt_in = ncnt_ff + 1'b1;
            sh_in   = hi_ff;
            if ((LEN_W'(hi_ff) + 1'b1) < len_ff) begin
               state_in = S_SH_RD;
            end else begin
               len_in   = len_ff - 1'b1;
               scan_in  = '0;
               rdv_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SH_RD: begin
            list_re  = 1'b1;
            list_ra  = sh_ff + 1'b1;
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            // close the gap left by the removed entry
            list_we   = 1'b1;
            list_wa   = sh_ff;
            list_wref = lref_rd_ff;
            list_ww   = lw_rd_ff;
            sh_in     = sh_ff + 1'b1;
            if ((LEN_W'(sh_ff) + LEN_W'(2)) < len_ff) begin
               state_in = S_SH_RD;
            end else begin
               len_in   = len_ff - 1'b1;
               scan_in  = '0;
               rdv_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_ROOT_RD: begin
            tree_re  = 1'b1;
            tree_ra  = rlo_ff;
            state_in = S_ROOT_WR;
         end
         S_ROOT_WR: begin
            root_in     = tree_rd_ff;
            cur_in      = tree_rd_ff;
            ready_in    = 1'b1;
            bit_in      = '0;
            pend_vld_in = 1'b0;
            state_in    = tree_rd_ff[LEAF_BIT] ? S_FLUSH : S_WALK;
         end
         S_WALK: begin
            if (!walk_hold) begin
               // the previous symbol is not the last of the run: release it
               out_push = leaf_hit && pend_vld_ff;
               cur_in   = cur_eff;
               if (leaf_hit) begin
                  pend_vld_in = 1'b1;
                  pend_sym_in = tree_rd_ff[SYM_LSB +: 8];
               end
               if (bit_ff < cmd.nbits) begin
                  tree_re = 1'b1;
                  tree_ra = code_bit ? cur_eff[NODE_AW-1:0]
                                     : cur_eff[2*NODE_AW-1:NODE_AW];
                  bit_in  = bit_ff + 1'b1;
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!(pend_vld_ff && !out_take)) begin
               out_push    = pend_vld_ff;
               out_last    = 1'b1;
               pend_vld_in = 1'b0;
               cmd_pop     = 1'b1;
               if (cmd.last) begin
                  len_in   = '0;
                  ncnt_in  = '0;
                  ready_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_wa] <= tree_wd;
      end
      if (tree_re) begin
         tree_rd_ff <= tree_mem[tree_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         lref_mem[list_wa] <= list_wref;
         lw_mem[list_wa]   <= list_ww;
      end
      if (list_re) begin
         lref_rd_ff <= lref_mem[list_ra];
         lw_rd_ff   <= lw_mem[list_ra];
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      wlo_ff      <= wlo_in;
      whi_ff      <= whi_in;
      rlo_ff      <= rlo_in;
      rhi_ff      <= rhi_in;
      sh_ff       <= sh_in;
      root_ff     <= root_in;
      cur_ff      <= cur_in;
      pend_sym_ff <= pend_sym_in;
      if (out_push) begin
         rsp_sym_ff  <= out_sym;
         rsp_last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         len_ff      <= '0;
         ncnt_ff     <= '0;
         ready_ff    <= 1'b0;
         scan_ff     <= '0;
         rdv_ff      <= 1'b0;
         hi_vld_ff   <= 1'b0;
         bit_ff      <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         len_ff      <= len_in;
         ncnt_ff     <= ncnt_in;
         ready_ff    <= ready_in;
         scan_ff     <= scan_in;
         rdv_ff      <= rdv_in;
         hi_vld_ff   <= hi_vld_in;
         bit_ff      <= bit_in;
         pend_vld_ff <= pend_vld_in;
         if (out_push) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_out_symbol  = rsp_sym_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_take)
      else $error("symbol pushed into an occupied output register");

   a_walk_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> ready_ff)
      else $error("tree walk without a built tree");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_SYMBOLS))
      else $error("alphabet list overflow");

   a_merge_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (hi_vld_ff && (len_ff >= LEN_W'(2))))
      else $error("merge without two list entries");

endmodule

/* hdl/huffman_tree_build_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_tree_build_decoder: Huffman tree build and payload decoder
// Input queue in front of a tree build and bit-serial decode engine.
// ----------------------------------------------------------------------------
// An alphabet entry is written to the list and node memories as it is taken
// from the queue. The first payload byte after loading builds the tree: each
// merge scans the working list once (one list-memory read per entry) and then
// moves the tail down with one read and one write per entry. A payload byte is
// then decoded with one node-memory read per decoded bit; the final symbol of a
// byte is held back until the byte ends so that it can carry last_of_run.
// No clearing pass follows reset. A four-deep command queue lets the input
// side run ahead of the engine.
module huffman_tree_build_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_entry_symbol,
   input  logic [31:0] req_entry_frequency,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [2:0]  req_pad_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_symbol,
   output logic        rsp_last_of_run
);
   import htbd_pkg::*;

   logic    cmd_vld;
   cmd_type cmd;
   logic    cmd_pop;

   htbd_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_entry_symbol    (req_entry_symbol),
      .req_entry_frequency (req_entry_frequency),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .req_pad_bits        (req_pad_bits),
      .cmd_vld             (cmd_vld),
      .cmd                 (cmd),
      .cmd_pop             (cmd_pop)
   );

   htbd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_vld         (cmd_vld),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_symbol  (rsp_out_symbol),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the Huffman tree build decoder
// Loads alphabets, sends payload bytes, predicts decoded symbols with its own
// copy of the tree and walk state, and checks every result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import htbd_pkg::*;

   localparam int STALL_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 110;
   localparam int QUIET_FROM = 90;

   typedef struct {
      op_type     kind;
      logic [7:0] sym;
      logic [31:0] freq;
      logic [7:0] dbyte;
      logic       last;
      logic [2:0] pad;
      int         typed_n;
      logic [7:0] typed_sym;
   } stim_row_type;

   typedef struct {
      logic [7:0] sym;
      logic       last;
   } decoded_type;

   // typed_n < 0: expectation comes from the predictor
   stim_row_type dir_rows [20] = '{
      '{OP_DATA,  8'h00, 32'h0,        8'hA5, 1'b0, 3'd0,  0, 8'h00},
      '{OP_ENTRY, 8'h00, 32'd5,        8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_ENTRY, 8'hFF, 32'd5,        8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_DATA,  8'h00, 32'h0,        8'h40, 1'b0, 3'd0, -1, 8'h00},
      '{OP_DATA,  8'h00, 32'h0,        8'h80, 1'b1, 3'd7,  1, 8'hFF},
      '{OP_ENTRY, 8'h42, 32'hFFFFFFFF, 8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_DATA,  8'h00, 32'h0,        8'hFF, 1'b1, 3'd0,  0, 8'h00},
      '{OP_ENTRY, 8'h11, 32'hFFFFFFFF, 8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_ENTRY, 8'h22, 32'hFFFFFFFF, 8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_ENTRY, 8'h33, 32'd1,        8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_DATA,  8'h00, 32'h0,        8'hA5, 1'b0, 3'd0, -1, 8'h00},
      '{OP_DATA,  8'h00, 32'h0,        8'h3C, 1'b1, 3'd3, -1, 8'h00},
      '{OP_ENTRY, 8'h01, 32'd3,        8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_ENTRY, 8'h02, 32'd7,        8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_ENTRY, 8'h03, 32'd0,        8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_DATA,  8'h00, 32'h0,        8'h5A, 1'b0, 3'd0, -1, 8'h00},
      '{OP_ENTRY, 8'h77, 32'd0,        8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_ENTRY, 8'h78, 32'd0,        8'h00, 1'b0, 3'd0, -1, 8'h00},
      '{OP_DATA,  8'h00, 32'h0,        8'hFF, 1'b1, 3'd0, -1, 8'h00},
      '{OP_DATA,  8'h00, 32'h0,        8'h00, 1'b1, 3'd0,  0, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [7:0]  req_entry_symbol = '0;
   logic [31:0] req_entry_frequency = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic [2:0]  req_pad_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_symbol;
   logic        rsp_last_of_run;

   int         row_typed_n = -1;
   logic [7:0] row_typed_sym = '0;
   bit         quiet = 1'b0;

   // predictor state
   logic [NODE_AW-1:0]     pl_ref [MAX_SYMBOLS];
   logic [WEIGHT_BITS-1:0] pl_weight [MAX_SYMBOLS];
   int                     pl_len = 0;
   logic                   pt_leaf [NODE_DEPTH];
   logic [7:0]             pt_sym [NODE_DEPTH];
   logic [NODE_AW-1:0]     pt_left [NODE_DEPTH];
   logic [NODE_AW-1:0]     pt_right [NODE_DEPTH];
   int                     pt_count = 0;
   int                     p_root = 0;
   bit                     p_ready = 1'b0;
   int                     p_walk = 0;

   decoded_type expected_symbols [$];
   decoded_type scratch [$];
   int errors = 0;
   int items_sent = 0;
   int symbols_checked = 0;
   int idle_cycles = 0;
   int rsp_burst = 0;

   huffman_tree_build_decoder i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_entry_symbol    (req_entry_symbol),
      .req_entry_frequency (req_entry_frequency),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .req_pad_bits        (req_pad_bits),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_symbol      (rsp_out_symbol),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task automatic clear_tree();
      pl_len = 0;
      pt_count = 0;
      p_root = 0;
      p_ready = 1'b0;
      p_walk = 0;
   endtask

   task automatic build_code_tree();
      int lo, hi, tmp, parent;
      logic [WEIGHT_BITS-1:0] wlo, whi, wt;
      logic [WEIGHT_BITS:0] sum;
      while (pl_len > 1) begin
         lo = 0; hi = 1;
         wlo = pl_weight[0]; whi = pl_weight[1];
         if (wlo > whi) begin
            wt = wlo; wlo = whi; whi = wt;
            lo = 1; hi = 0;
         end
         for (int i = 2; i < pl_len; i++) begin
            if (pl_weight[i] < wlo) begin
               whi = wlo; hi = lo;
               wlo = pl_weight[i]; lo = i;
            end else if (pl_weight[i] < whi) begin
               whi = pl_weight[i]; hi = i;
            end
         end
         parent = pt_count % NODE_DEPTH;
         pt_leaf[parent] = 1'b0;
         pt_sym[parent] = '0;
         pt_left[parent] = pl_ref[lo];
         pt_right[parent] = pl_ref[hi];
         pt_count++;
         sum = {1'b0, wlo} + {1'b0, whi};
         pl_ref[lo] = parent[NODE_AW-1:0];
         pl_weight[lo] = sum[WEIGHT_BITS] ? '1 : sum[WEIGHT_BITS-1:0];
         for (int i = hi; i + 1 < pl_len; i++) begin
            pl_ref[i] = pl_ref[i + 1];
            pl_weight[i] = pl_weight[i + 1];
         end
         pl_len--;
      end
      tmp = pl_ref[0];
      p_root = tmp % NODE_DEPTH;
      p_walk = p_root;
      p_ready = 1'b1;
   endtask

   // Advance the predictor by one accepted input transaction; results go to scratch
   task automatic predict_symbols(input logic kind, input logic [7:0] sym,
                                  input logic [31:0] freq, input logic [7:0] dbyte,
                                  input logic last, input logic [2:0] pad);
      int nbits, nxt;
      scratch.delete();
      if (kind == OP_ENTRY) begin
         if (p_ready) clear_tree();
         if (pl_len < MAX_SYMBOLS) begin
            pt_leaf[pl_len] = 1'b1;
            pt_sym[pl_len] = sym;
            pt_left[pl_len] = '0;
            pt_right[pl_len] = '0;
            pl_ref[pl_len] = pl_len[NODE_AW-1:0];
            pl_weight[pl_len] = freq;
            pl_len++;
            pt_count = pl_len;
         end
         return;
      end
      if (!p_ready) begin
         if (pl_len == 0) return;
         build_code_tree();
      end
      nbits = last ? 8 - pad : 8;
      if (!pt_leaf[p_root]) begin
         for (int b = 0; b < nbits; b++) begin
            nxt = dbyte[7 - b] ? pt_right[p_walk] : pt_left[p_walk];
            nxt = nxt % NODE_DEPTH;
            if (pt_leaf[nxt]) begin
               scratch.insert(scratch.size(), '{pt_sym[nxt], 1'b0});
               p_walk = p_root;
            end else begin
               p_walk = nxt;
            end
         end
      end
      if (scratch.size() > 0) scratch[scratch.size() - 1].last = 1'b1;
      if (last) clear_tree();
   endtask

   task automatic send(input stim_row_type r);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_kind <= r.kind;
      req_entry_symbol <= r.sym;
      req_entry_frequency <= r.freq;
      req_data_byte <= r.dbyte;
      req_last_byte <= r.last;
      req_pad_bits <= r.pad;
      row_typed_n <= r.typed_n;
      row_typed_sym <= r.typed_sym;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_frequency();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return $urandom;
         2: return 32'hFFFFFFFF;
         default: return $urandom_range(1, 100);
      endcase
   endfunction

   // input side: predict on every accepted transaction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_symbols(req_kind, req_entry_symbol, req_entry_frequency,
                         req_data_byte, req_last_byte, req_pad_bits);
         if (row_typed_n == 0) begin
            scratch.delete();
         end else if (row_typed_n == 1) begin
            scratch.delete();
            scratch.insert(0, '{row_typed_sym, 1'b1});
         end
         foreach (scratch[i]) expected_symbols.insert(expected_symbols.size(), scratch[i]);
      end
   end

   // result side: compare with the oldest expectation
   always @(posedge clock) begin
      decoded_type exp_item;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            report($sformatf("unexpected symbol %02h", rsp_out_symbol));
         end else begin
            exp_item = expected_symbols.pop_front();
            symbols_checked++;
            if (rsp_out_symbol !== exp_item.sym)
               report($sformatf("symbol %02h, expected %02h", rsp_out_symbol, exp_item.sym));
            if (rsp_last_of_run !== exp_item.last)
               report($sformatf("last_of_run %0b, expected %0b on symbol %02h",
                                rsp_last_of_run, exp_item.last, exp_item.sym));
         end
      end
   end

   // receiver stall in bursts
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (rsp_burst > 0) begin
         rsp_stall <= 1'b1;
         rsp_burst <= rsp_burst - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         rsp_burst <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      stim_row_type r;
      int n_entries, n_bytes;
      bit abandon;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send(dir_rows[i]);

      // hold off until the directed results have drained
      req_valid <= 1'b0;
      while (expected_symbols.size() != 0) @(negedge clock);

      while (items_sent < RANDOM_ITEMS) begin
         quiet = items_sent >= QUIET_FROM;
         n_entries = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
         for (int i = 0; i < n_entries; i++)
            send('{OP_ENTRY, 8'($urandom), random_frequency(), 8'($urandom),
                   1'($urandom), 3'($urandom), -1, 8'h00});
         n_bytes = $urandom_range(1, 5);
         abandon = $urandom_range(0, 7) == 0;
         for (int i = 0; i < n_bytes; i++) begin
            r = '{OP_DATA, 8'($urandom), 32'($urandom), 8'($urandom),
                  (i == n_bytes - 1) && !abandon, 3'($urandom), -1, 8'h00};
            send(r);
         end
         // payload on an empty alphabet: ignored
         if (!abandon && $urandom_range(0, 9) == 0) begin
            send('{OP_DATA, 8'($urandom), 32'($urandom), 8'($urandom), 1'($urandom),
                   3'($urandom), -1, 8'h00});
         end
      end

      req_valid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (expected_symbols.size() != 0)
         report($sformatf("%0d symbols never arrived", expected_symbols.size()));

      $display("summary: %0d transactions of directed rows and random streams sent;",
               items_sent);
      $display("summary: %0d symbols checked, %0d mismatches", symbols_checked, errors);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
hdl/htbd_pkg.sv
hdl/htbd_front.sv
hdl/htbd_back.sv
hdl/huffman_tree_build_decoder.sv
test/tb_top.sv
